// ===== hdl/multiband_noise_gate_defines.svh =====
// ---------------------------------------------------------------------------
// multiband_noise_gate_defines.svh
// Assertion macros for the multiband noise gate.
// ---------------------------------------------------------------------------
`ifndef MULTIBAND_NOISE_GATE_DEFINES_SVH
`define MULTIBAND_NOISE_GATE_DEFINES_SVH
`ifndef SYNTHESIS
`define MNG_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MNG_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define MNG_ASSERT(lbl, clk, rstn, prop, msg)
`define MNG_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== hdl/mng_pkg.sv =====
// ---------------------------------------------------------------------------
// mng_pkg
// Shared types and constants of the multiband noise gate.
// ---------------------------------------------------------------------------
package mng_pkg;

	localparam int HIST_W = 32;
	localparam int MIX_W  = HIST_W + 17;
	localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd394566;
	localparam logic signed [63:0] LEVEL_OFFSET_Q8 = 64'sd30720;
	localparam logic [15:0] UNITY_CODE = 16'hFFFF;

	typedef enum logic [2:0] {
		REG_LP_GAIN  = 3'd0,
		REG_HP_GAIN  = 3'd1,
		REG_FB_ONE   = 3'd2,
		REG_FB_TWO   = 3'd3,
		REG_SPAN     = 3'd4,
		REG_FLOOR    = 3'd5,
		REG_ATTACK   = 3'd6,
		REG_RELEASE  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_XOVER,
		T_GATE,
		T_SUM
	} top_state_t;

	typedef enum logic [3:0] {
		G_IDLE,
		G_ENV1,
		G_ENV2,
		G_NORM,
		G_SQR,
		G_DB,
		G_DBR,
		G_SPAN,
		G_F2,
		G_SS,
		G_GN,
		G_MIX
	} gate_state_t;

	typedef struct packed {
		logic [15:0] att_coef;
		logic [15:0] rel_coef;
		logic [15:0] span;
		logic [15:0] floor_gain;
	} gate_cfg_t;

endpackage

// ===== hdl/mng_in_if.sv =====
// ---------------------------------------------------------------------------
// mng_in_if
// Input sample channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface mng_in_if #(parameter int SAMPLE_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

// ===== hdl/mng_out_if.sv =====
// ---------------------------------------------------------------------------
// mng_out_if
// Result channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface mng_out_if #(parameter int SAMPLE_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic [63:0] band_gain_pack;
	logic [63:0] band_level_pack;
	modport source(output valid, output sample_out, output band_gain_pack,
		output band_level_pack, input ready);
	modport sink(input valid, input sample_out, input band_gain_pack,
		input band_level_pack, output ready);
endinterface

// ===== hdl/mng_xover_cell.sv =====
// ---------------------------------------------------------------------------
// mng_xover_cell
// One Linkwitz-Riley crossover: two highpass then two lowpass biquads on
// a shared multiplier. The highpass result is handed to the next cell as
// soon as it is ready.
// ---------------------------------------------------------------------------
module mng_xover_cell import mng_pkg::*; #(
	parameter int COEF_WIDTH = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [HIST_W-1:0]     x_in,
	input  logic [COEF_WIDTH-1:0]        lp_gain,
	input  logic [COEF_WIDTH-1:0]        hp_gain,
	input  logic signed [COEF_WIDTH-1:0] fb_one,
	input  logic signed [COEF_WIDTH-1:0] fb_two,
	output logic                         hp_valid,
	output logic signed [HIST_W-1:0]     hp_out,
	output logic                         done,
	output logic signed [HIST_W-1:0]     lp_out,
	output logic                         busy
);

	localparam int TW = HIST_W + 3;
	localparam int PW = COEF_WIDTH + 1 + TW;
	localparam int AW = PW + 3;
	localparam logic signed [AW-1:0] YMAX = (AW'(1) <<< (HIST_W - 1)) - AW'(1);
	localparam logic signed [AW-1:0] YMIN = -YMAX - AW'(1);
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (COEF_WIDTH - 2);

	logic                     busy_q;
	logic [1:0]               bq_q;
	logic [2:0]               ph_q;
	logic signed [HIST_W-1:0] x_q, bin_q, hp_q, lp_q;
	logic                     hpv_q, done_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [AW-1:0]     acc_q;
	logic signed [HIST_W-1:0] x1_q [4];
	logic signed [HIST_W-1:0] x2_q [4];
	logic signed [HIST_W-1:0] y1_q [4];
	logic signed [HIST_W-1:0] y2_q [4];

	logic                     hp_sel;
	logic signed [TW-1:0]     taps, t_x1;
	logic signed [COEF_WIDTH:0] op_a;
	logic signed [TW-1:0]     op_b;
	logic signed [PW-1:0]     mult;
	logic signed [AW-1:0]     rnd;
	logic signed [HIST_W-1:0] y;

	assign hp_sel = !bq_q[1];
	assign t_x1   = TW'(x1_q[bq_q]) <<< 1;
	assign taps   = TW'(bin_q) + (hp_sel ? -t_x1 : t_x1) + TW'(x2_q[bq_q]);

	always_comb begin
		case (ph_q)
			3'd0: begin
				op_a = {1'b0, (hp_sel ? hp_gain : lp_gain)};
				op_b = taps;
			end
			3'd1: begin
				op_a = (COEF_WIDTH+1)'(fb_one);
				op_b = TW'(y1_q[bq_q]);
			end
			3'd2: begin
				op_a = (COEF_WIDTH+1)'(fb_two);
				op_b = TW'(y2_q[bq_q]);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mult = PW'(op_a) * PW'(op_b);
	assign rnd  = (acc_q + HALF) >>> (COEF_WIDTH - 1);
	assign y    = (rnd > YMAX) ? HIST_W'(YMAX) : ((rnd < YMIN) ? HIST_W'(YMIN) : HIST_W'(rnd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bq_q   <= '0;
			ph_q   <= '0;
			hpv_q  <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else begin
			hpv_q  <= 1'b0;
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bq_q   <= '0;
				ph_q   <= '0;
			end else if (busy_q) begin
				if (ph_q == 3'd4) begin
					x2_q[bq_q] <= x1_q[bq_q];
					x1_q[bq_q] <= bin_q;
					y2_q[bq_q] <= y1_q[bq_q];
					y1_q[bq_q] <= y;
					ph_q <= '0;
					bq_q <= bq_q + 2'd1;
					if (bq_q == 2'd1) begin
						hpv_q <= 1'b1;
					end
					if (bq_q == 2'd3) begin
						done_q <= 1'b1;
						busy_q <= 1'b0;
					end
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x_in;
			bin_q <= x_in;
		end else if (busy_q) begin
			prod_q <= mult;
			case (ph_q)
				3'd1: acc_q <= AW'(prod_q);
				3'd2, 3'd3: acc_q <= acc_q - (AW'(prod_q) <<< 1);
				3'd4: begin
					bin_q <= (bq_q == 2'd1) ? x_q : y;
					if (bq_q == 2'd1) begin
						hp_q <= y;
					end
					if (bq_q == 2'd3) begin
						lp_q <= y;
					end
				end
				default: ;
			endcase
		end
	end

	assign hp_valid = hpv_q;
	assign hp_out   = hp_q;
	assign done     = done_q;
	assign lp_out   = lp_q;
	assign busy     = busy_q;

endmodule

// ===== hdl/mng_gate_cell.sv =====
// ---------------------------------------------------------------------------
// mng_gate_cell
// Per-band envelope follower, log2 level, smoothstep gain and band mix on
// one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
module mng_gate_cell import mng_pkg::*; #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [HIST_W-1:0] band,
	input  gate_cfg_t                cfg,
	output logic                     busy,
	output logic [15:0]              gain,
	output logic [15:0]              level,
	output logic signed [MIX_W-1:0]  mix
);

	localparam logic [32:0] AMAX = (33'(1) << SAMPLE_WIDTH) - 33'(1);

	gate_state_t st_q, st_d;
	logic [31:0]             mag_q;
	logic                    neg_q, lneg_q;
	logic [SAMPLE_WIDTH-1:0] a_q, env_q;
	logic [15:0]             c_q, frac_q, lvl_q, gain_q;
	logic [63:0]             w_q;
	logic [31:0]             nm_q;
	logic [4:0]              sh_q;
	logic [3:0]              cnt_q;
	logic [16:0]             f_q, f2_q, s_q;
	logic signed [MIX_W-1:0] mix_q;

	logic [31:0] op_a, op_b, mag_in;
	logic [63:0] prod, env_sum;
	logic [32:0] mag_w, sq;
	logic [SAMPLE_WIDTH-1:0] a_in, env_next;
	logic [4:0]  nstep;
	logic        nzero;
	logic signed [6:0]  e_val;
	logic signed [22:0] l_val, l_mag;
	logic signed [63:0] db_v, db_r;
	logic [16:0] fl, f_raw, g_sum, geff;
	logic [63:0] f_full;

	assign mag_w  = (band < 0) ? -33'(band) : 33'(band);
	assign mag_in = mag_w[31:0];
	assign a_in   = (mag_w > AMAX) ? SAMPLE_WIDTH'(AMAX) : SAMPLE_WIDTH'(mag_w);
	assign env_sum  = w_q + prod + 64'd32768;
	assign env_next = SAMPLE_WIDTH'(env_sum >> 16);
	assign sq     = 33'(prod >> 31);
	assign e_val  = 7'(32 - SAMPLE_WIDTH) - 7'(sh_q);
	assign l_val  = {e_val, frac_q};
	assign l_mag  = l_val[22] ? -l_val : l_val;
	assign db_v   = lneg_q ? -$signed(w_q) : $signed(w_q);
	assign db_r   = ((db_v + 64'sd8388608) >>> 24) + LEVEL_OFFSET_Q8;
	assign fl     = (cfg.floor_gain == UNITY_CODE) ? 17'h10000 : {1'b0, cfg.floor_gain};
	assign f_full = prod >> 8;
	assign f_raw  = (f_full > 64'h10000) ? 17'h10000 : f_full[16:0];
	assign g_sum  = fl + 17'(prod >> 16);
	assign geff   = (gain_q == UNITY_CODE) ? 17'h10000 : {1'b0, gain_q};

	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin nstep = 5'd16; nzero = (nm_q[31:16] == '0); end
			3'd1: begin nstep = 5'd8;  nzero = (nm_q[31:24] == '0); end
			3'd2: begin nstep = 5'd4;  nzero = (nm_q[31:28] == '0); end
			3'd3: begin nstep = 5'd2;  nzero = (nm_q[31:30] == '0); end
			default: begin nstep = 5'd1; nzero = !nm_q[31]; end
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (st_q)
			G_ENV1: begin op_a = 32'(c_q); op_b = 32'(env_q); end
			G_ENV2: begin op_a = 32'(17'h10000 - 17'(c_q)); op_b = 32'(a_q); end
			G_SQR:  begin op_a = nm_q; op_b = nm_q; end
			G_DB:   begin op_a = 32'(l_mag); op_b = DB_PER_LOG2_Q16; end
			G_SPAN: begin op_a = 32'(lvl_q); op_b = 32'(cfg.span); end
			G_F2:   begin op_a = 32'(f_q); op_b = 32'(f_q); end
			G_SS:   begin op_a = 32'(f2_q); op_b = 32'(18'd196608 - 18'({f_q, 1'b0})); end
			G_GN:   begin op_a = 32'(17'h10000 - fl); op_b = 32'(s_q); end
			G_MIX:  begin op_a = mag_q; op_b = 32'(geff); end
			default: ;
		endcase
	end

	assign prod = 64'(op_a) * 64'(op_b);

	always_comb begin
		st_d = st_q;
		case (st_q)
			G_IDLE: if (start) st_d = G_ENV1;
			G_ENV1: st_d = G_ENV2;
			G_ENV2: st_d = (env_next == '0) ? G_SPAN : G_NORM;
			G_NORM: if (cnt_q == 4'd4) st_d = G_SQR;
			G_SQR:  if (cnt_q == 4'd15) st_d = G_DB;
			G_DB:   st_d = G_DBR;
			G_DBR:  st_d = G_SPAN;
			G_SPAN: st_d = G_F2;
			G_F2:   st_d = G_SS;
			G_SS:   st_d = G_GN;
			G_GN:   st_d = G_MIX;
			G_MIX:  st_d = G_IDLE;
			default: st_d = G_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= G_IDLE;
			env_q  <= '0;
			gain_q <= UNITY_CODE;
			cnt_q  <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				G_ENV2: begin
					env_q <= env_next;
					cnt_q <= '0;
				end
				G_NORM: cnt_q <= (cnt_q == 4'd4) ? 4'd0 : cnt_q + 4'd1;
				G_SQR:  cnt_q <= cnt_q + 4'd1;
				G_GN:   gain_q <= g_sum[16] ? UNITY_CODE : g_sum[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			G_IDLE: begin
				mag_q <= mag_in;
				neg_q <= band[HIST_W-1];
				a_q   <= a_in;
				c_q   <= (a_in > env_q) ? cfg.att_coef : cfg.rel_coef;
			end
			G_ENV1: w_q <= prod;
			G_ENV2: begin
				nm_q   <= 32'(env_next);
				sh_q   <= '0;
				frac_q <= '0;
				lvl_q  <= '0;
			end
			G_NORM: begin
				if (nzero) begin
					nm_q <= nm_q << nstep;
					sh_q <= sh_q + nstep;
				end
			end
			G_SQR: begin
				if (sq[32]) begin
					frac_q[4'd15 - cnt_q] <= 1'b1;
					nm_q <= sq[32:1];
				end else begin
					nm_q <= sq[31:0];
				end
			end
			G_DB: begin
				w_q    <= prod;
				lneg_q <= l_val[22];
			end
			G_DBR: begin
				if (db_r < 0) begin
					lvl_q <= '0;
				end else if (db_r > 64'sd65535) begin
					lvl_q <= 16'hFFFF;
				end else begin
					lvl_q <= db_r[15:0];
				end
			end
			G_SPAN: f_q  <= f_raw;
			G_F2:   f2_q <= 17'(prod >> 16);
			G_SS:   s_q  <= 17'(prod >> 16);
			G_MIX:  mix_q <= neg_q ? -$signed(MIX_W'(prod)) : $signed(MIX_W'(prod));
			default: ;
		endcase
	end

	assign busy  = (st_q != G_IDLE);
	assign gain  = gain_q;
	assign level = lvl_q;
	assign mix   = mix_q;

endmodule

// ===== hdl/multiband_noise_gate.sv =====
// ---------------------------------------------------------------------------
// multiband_noise_gate
// Linkwitz-Riley crossover chain feeding per-band noise gates.
// ---------------------------------------------------------------------------
// One sample is in flight at a time. Each crossover cell runs four biquads
// on one multiplier and starts the next cell as soon as its own highpass
// result is ready, after its second biquad. When the last cell is done,
// the gate cells start together and run in parallel (a 16-step log2
// squaring loop dominates). Once all of them are idle, the saturated sum
// is loaded into the output register, waiting while the previous result
// still blocks the output register. A new sample is taken while the
// previous result still waits in the output register.
// ---------------------------------------------------------------------------
`include "multiband_noise_gate_defines.svh"

module multiband_noise_gate import mng_pkg::*; #(
	parameter int NUM_BANDS    = 4,
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 21
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	mng_in_if.sink       audio_in,
	mng_out_if.source    audio_out
);

	localparam int NX    = NUM_BANDS - 1;
	localparam int SUM_W = MIX_W + $clog2(NUM_BANDS) + 1;
	localparam logic signed [SUM_W-1:0] SMAX = (SUM_W'(1) <<< (SAMPLE_WIDTH - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

	logic [63:0] regs_q [8];
	logic        wr_en;
	reg_idx_t    wr_idx;

	top_state_t state_q, state_d;
	logic       accept, load, gate_start;

	logic                     xo_start [NX];
	logic signed [HIST_W-1:0] xo_x     [NX];
	logic signed [HIST_W-1:0] xo_hp    [NX];
	logic signed [HIST_W-1:0] xo_lp    [NX];
	logic                     xo_hpv   [NX];
	logic                     xo_done  [NX];
	logic [NX-1:0]            xo_busy;

	logic signed [HIST_W-1:0] band   [NUM_BANDS];
	logic [15:0]              g_gain [NUM_BANDS];
	logic [15:0]              g_lvl  [NUM_BANDS];
	logic signed [MIX_W-1:0]  g_mix  [NUM_BANDS];
	logic [NUM_BANDS-1:0]     g_busy;

	logic signed [SUM_W-1:0]  sum, rnd;
	logic [63:0]              gpack, lpack;

	logic                          out_v_q;
	logic signed [SAMPLE_WIDTH-1:0] out_s_q;
	logic [63:0]                   out_g_q, out_l_q;

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign wr_idx = reg_idx_t'(paddr[5:3]);
	assign prdata = regs_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= '0;
			end
			regs_q[REG_FLOOR] <= '1;
		end else if (wr_en) begin
			case (wr_idx)
				REG_LP_GAIN, REG_HP_GAIN, REG_FB_ONE, REG_FB_TWO:
					regs_q[wr_idx] <= {1'b0, pwdata[62:0]};
				default: regs_q[wr_idx] <= pwdata;
			endcase
		end
	end

	// control
	assign accept = audio_in.valid && audio_in.ready;
	assign load   = (state_q == T_SUM) && (!out_v_q || audio_out.ready);
	assign gate_start = (state_q == T_XOVER) && xo_done[NX-1];
	assign audio_in.ready = (state_q == T_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE:  if (accept) state_d = T_XOVER;
			T_XOVER: if (xo_done[NX-1]) state_d = T_GATE;
			T_GATE:  if (g_busy == '0) state_d = T_SUM;
			T_SUM:   if (load) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// crossover chain
	for (genvar k = 0; k < NX; k++) begin : g_xo
		if (k == 0) begin : g_head
			assign xo_start[k] = accept;
			assign xo_x[k]     = HIST_W'(audio_in.sample_in);
		end else begin : g_link
			assign xo_start[k] = xo_hpv[k-1];
			assign xo_x[k]     = xo_hp[k-1];
		end
		mng_xover_cell #(.COEF_WIDTH(COEF_WIDTH)) u_xo (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (xo_start[k]),
			.x_in     (xo_x[k]),
			.lp_gain  (regs_q[REG_LP_GAIN][k*COEF_WIDTH +: COEF_WIDTH]),
			.hp_gain  (regs_q[REG_HP_GAIN][k*COEF_WIDTH +: COEF_WIDTH]),
			.fb_one   (regs_q[REG_FB_ONE][k*COEF_WIDTH +: COEF_WIDTH]),
			.fb_two   (regs_q[REG_FB_TWO][k*COEF_WIDTH +: COEF_WIDTH]),
			.hp_valid (xo_hpv[k]),
			.hp_out   (xo_hp[k]),
			.done     (xo_done[k]),
			.lp_out   (xo_lp[k]),
			.busy     (xo_busy[k])
		);
		assign band[k] = xo_lp[k];
	end
	assign band[NUM_BANDS-1] = xo_hp[NX-1];

	// gates
	for (genvar k = 0; k < NUM_BANDS; k++) begin : g_gate
		gate_cfg_t cfg;
		assign cfg.att_coef   = regs_q[REG_ATTACK][16*k +: 16];
		assign cfg.rel_coef   = regs_q[REG_RELEASE][16*k +: 16];
		assign cfg.span       = regs_q[REG_SPAN][16*k +: 16];
		assign cfg.floor_gain = regs_q[REG_FLOOR][16*k +: 16];
		mng_gate_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_gate (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (gate_start),
			.band   (band[k]),
			.cfg    (cfg),
			.busy   (g_busy[k]),
			.gain   (g_gain[k]),
			.level  (g_lvl[k]),
			.mix    (g_mix[k])
		);
	end

	always_comb begin
		sum   = '0;
		gpack = '0;
		lpack = '0;
		for (int k = 0; k < NUM_BANDS; k++) begin
			sum = sum + SUM_W'(g_mix[k]);
			gpack[16*k +: 16] = g_gain[k];
			lpack[16*k +: 16] = g_lvl[k];
		end
	end

	assign rnd = (sum + SUM_W'(32768)) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (audio_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_s_q <= (rnd > SMAX) ? SAMPLE_WIDTH'(SMAX) :
				((rnd < SMIN) ? SAMPLE_WIDTH'(SMIN) : SAMPLE_WIDTH'(rnd));
			out_g_q <= gpack;
			out_l_q <= lpack;
		end
	end

	assign audio_out.valid           = out_v_q;
	assign audio_out.sample_out      = out_s_q;
	assign audio_out.band_gain_pack  = out_g_q;
	assign audio_out.band_level_pack = out_l_q;

	`MNG_ASSERT(a_accept_starts, clk, arst_n, accept |=> state_q == T_XOVER, "transfer did not start crossover")
	`MNG_ASSERT(a_xo_in_xover, clk, arst_n, (xo_busy != '0) |-> state_q == T_XOVER, "crossover busy outside XOVER")
	`MNG_ASSERT(a_gate_in_gate, clk, arst_n, (g_busy != '0) |-> state_q == T_GATE, "gate busy outside GATE")
	`MNG_NEVER(a_no_overwrite, clk, arst_n, load && out_v_q && !audio_out.ready, "result overwritten")

endmodule
